>>> rtl/core/frpc_pkg.sv
// Shared types and constants for the FIFO ring-pool cache insert block.
package frpc_pkg;

  localparam int KEY_BITS       = 8;
  localparam int KEY_ENTRIES    = 1 << KEY_BITS;
  localparam int SLOT_BITS      = 8;
  localparam int TAG_BITS       = 16;
  localparam int VALUE_BITS     = 32;
  localparam int LEN_BITS       = 9;
  localparam int POOL_SLOTS_DEF = 255;

  localparam logic [LEN_BITS-1:0]  RUN_MAX    = '1;
  localparam logic [SLOT_BITS-1:0] CLEAR_LAST = '1;

  typedef struct packed {
    logic [KEY_BITS-1:0]   put_key;
    logic [TAG_BITS-1:0]   put_tag;
    logic [VALUE_BITS-1:0] put_value;
  } put_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] written_slot;
    logic                 appended;
    logic [LEN_BITS-1:0]  run_length;
    logic                 evicted_valid;
    logic [KEY_BITS-1:0]  evicted_key;
  } res_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [KEY_BITS-1:0]   key;
    logic                  first;
    logic [LEN_BITS-1:0]   len;
    logic [VALUE_BITS-1:0] value;
  } slot_word_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [KEY_BITS-1:0]  addr;
    logic [SLOT_BITS-1:0] wdata;
  } kt_req_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [SLOT_BITS-1:0] addr;
    slot_word_t           wdata;
  } slot_req_t;

endpackage

>>> rtl/core/frpc_key_store.sv
// Key table memory: first slot of each key's run, one port, registered read.
module frpc_key_store (
  input  logic                         clk,
  input  frpc_pkg::kt_req_t            req,
  output logic [frpc_pkg::SLOT_BITS-1:0] rdata
);
  import frpc_pkg::*;

  logic [SLOT_BITS-1:0] mem [0:KEY_ENTRIES-1];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

>>> rtl/core/frpc_slot_store.sv
// Pool slot memory: header, run length and value per slot, one port, registered read.
module frpc_slot_store #(
  parameter int POOL_SLOTS = frpc_pkg::POOL_SLOTS_DEF
) (
  input  logic                  clk,
  input  frpc_pkg::slot_req_t   req,
  output frpc_pkg::slot_word_t  rdata
);
  import frpc_pkg::*;

  slot_word_t mem [0:POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        if (req.addr <= SLOT_BITS'(POOL_SLOTS)) begin
          mem[req.addr] <= req.wdata;
        end
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

>>> rtl/core/frpc_seq.sv
// Sequencer: clearing pass, dependent reads, update and write-back, result register.
module frpc_seq #(
  parameter int POOL_SLOTS = frpc_pkg::POOL_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           put_valid,
  output logic                           put_stall,
  input  frpc_pkg::put_t                 put_item,
  output logic                           res_valid,
  input  logic                           res_stall,
  output frpc_pkg::res_t                 res_item,
  output frpc_pkg::kt_req_t              kt_req,
  input  logic [frpc_pkg::SLOT_BITS-1:0] kt_rdata,
  output frpc_pkg::slot_req_t            slot_req,
  input  frpc_pkg::slot_word_t           slot_rdata
);
  import frpc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_WR
  } state_t;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(POOL_SLOTS);
  localparam logic [SLOT_BITS-1:0] FIRST_SLOT = SLOT_BITS'(1);

  state_t               state;
  logic [SLOT_BITS-1:0] wp;
  logic [SLOT_BITS-1:0] clr;
  put_t                 cur;
  logic [SLOT_BITS-1:0] head;
  slot_word_t           hdr_wp;
  logic                 app;
  logic [LEN_BITS-1:0]  len;
  logic                 evict;

  logic                 out_free;
  logic                 app_next;
  logic [LEN_BITS-1:0]  len_next;
  logic                 evict_next;
  logic [SLOT_BITS-1:0] wp_next;
  slot_word_t           head_word;
  slot_word_t           wp_word;

  assign out_free  = !res_valid || !res_stall;
  assign put_stall = (state != ST_IDLE);
  assign wp_next   = (wp >= LAST_SLOT) ? FIRST_SLOT : wp + FIRST_SLOT;

  always_comb begin
    app_next   = (head != '0) && (slot_rdata.tag == cur.put_tag);
    len_next   = LEN_BITS'(1);
    if (app_next) begin
      len_next = (slot_rdata.len == RUN_MAX) ? RUN_MAX : slot_rdata.len + LEN_BITS'(1);
    end
    evict_next = hdr_wp.first && (kt_rdata == wp);

    head_word     = slot_rdata;
    head_word.len = len_next;

    if (app) begin
      wp_word       = hdr_wp;
      wp_word.first = 1'b0;
      wp_word.value = cur.put_value;
      if (head == wp) begin
        wp_word.len = len;
      end
    end else begin
      wp_word.tag   = cur.put_tag;
      wp_word.key   = cur.put_key;
      wp_word.first = 1'b1;
      wp_word.len   = LEN_BITS'(1);
      wp_word.value = cur.put_value;
    end
  end

  always_comb begin
    kt_req   = '0;
    slot_req = '0;
    case (state)
      ST_CLEAR: begin
        kt_req.en     = 1'b1;
        kt_req.we     = 1'b1;
        kt_req.addr   = clr;
        slot_req.en   = 1'b1;
        slot_req.we   = 1'b1;
        slot_req.addr = clr;
      end
      ST_IDLE: begin
        kt_req.en     = put_valid;
        kt_req.addr   = put_item.put_key;
        slot_req.en   = put_valid;
        slot_req.addr = wp;
      end
      ST_RD1: begin
        kt_req.en     = 1'b1;
        kt_req.addr   = slot_rdata.key;
        slot_req.en   = 1'b1;
        slot_req.addr = kt_rdata;
      end
      ST_RD2: begin
        kt_req.en      = evict_next;
        kt_req.we      = 1'b1;
        kt_req.addr    = hdr_wp.key;
        slot_req.en    = app_next;
        slot_req.we    = 1'b1;
        slot_req.addr  = head;
        slot_req.wdata = head_word;
      end
      ST_WR: begin
        kt_req.en      = out_free && !app;
        kt_req.we      = 1'b1;
        kt_req.addr    = cur.put_key;
        kt_req.wdata   = wp;
        slot_req.en    = out_free;
        slot_req.we    = 1'b1;
        slot_req.addr  = wp;
        slot_req.wdata = wp_word;
      end
      default: begin
        kt_req   = '0;
        slot_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      wp        <= FIRST_SLOT;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != ST_WR) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + SLOT_BITS'(1);
          if (clr == CLEAR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (put_valid) begin
            cur   <= put_item;
            state <= ST_RD1;
          end
        end
        ST_RD1: begin
          head   <= kt_rdata;
          hdr_wp <= slot_rdata;
          state  <= ST_RD2;
        end
        ST_RD2: begin
          app   <= app_next;
          len   <= len_next;
          evict <= evict_next;
          state <= ST_WR;
        end
        ST_WR: begin
          if (out_free) begin
            res_valid              <= 1'b1;
            res_item.written_slot  <= wp;
            res_item.appended      <= app;
            res_item.run_length    <= len;
            res_item.evicted_valid <= evict;
            res_item.evicted_key   <= evict ? hdr_wp.key : '0;
            wp                     <= wp_next;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/fifo_ring_pool_cache_insert.sv
// Top level of the FIFO ring-pool cache insert block.
// Each put passes through the transfer, a read of the key table and of the slot at the
// write pointer, a second dependent read of the run's first slot and of the key entry
// named by the overwritten header, and a write-back step that also loads the result
// register. The next put is taken in the cycle after write-back, and write-back waits
// while a previous result is still stalled. After reset a clearing pass empties the key
// table and the slot headers, during which put_stall stays high.
module fifo_ring_pool_cache_insert #(
  parameter int POOL_SLOTS = frpc_pkg::POOL_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           put_valid,
  output logic           put_stall,
  input  frpc_pkg::put_t put_item,
  output logic           res_valid,
  input  logic           res_stall,
  output frpc_pkg::res_t res_item
);
  import frpc_pkg::*;

  kt_req_t              kt_req;
  logic [SLOT_BITS-1:0] kt_rdata;
  slot_req_t            slot_req;
  slot_word_t           slot_rdata;

  frpc_key_store u_key_store (
    .clk   (clk),
    .req   (kt_req),
    .rdata (kt_rdata)
  );

  frpc_slot_store #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_slot_store (
    .clk   (clk),
    .req   (slot_req),
    .rdata (slot_rdata)
  );

  frpc_seq #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .put_valid  (put_valid),
    .put_stall  (put_stall),
    .put_item   (put_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .kt_req     (kt_req),
    .kt_rdata   (kt_rdata),
    .slot_req   (slot_req),
    .slot_rdata (slot_rdata)
  );

endmodule

>>> rtl/core/frpc_checker.sv
// Port-level assertions for the FIFO ring-pool cache insert block, bound to the top level.
module frpc_checker (
  input logic           clk,
  input logic           rst,
  input logic           put_valid,
  input logic           put_stall,
  input frpc_pkg::put_t put_item,
  input logic           res_valid,
  input logic           res_stall,
  input frpc_pkg::res_t res_item
);
  import frpc_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("Stalled result changed or was dropped.");

  a_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.written_slot != '0)
    else $error("Result reports the reserved slot.");

  a_new_run_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.appended |-> res_item.run_length == LEN_BITS'(1))
    else $error("A new run does not report length one.");

  a_evict_key: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.evicted_valid |-> res_item.evicted_key == '0)
    else $error("Evicted key is not zero without an eviction.");

  a_reset_stall: assert property (@(posedge clk)
    rst |=> put_stall)
    else $error("Input taken during the clearing pass.");

endmodule

bind fifo_ring_pool_cache_insert frpc_checker u_frpc_checker (.*);
